// ----- rtl/core/esn_pkg.sv -----
// ----------------------------------------------------------------------------
// esn_pkg
// Shared types and constants for the eventual-safe-node finder.
// ----------------------------------------------------------------------------
package esn_pkg;

	// Fixed field widths of the stream and configuration ports
	localparam int NODE_W   = 6;   // node index on the ports
	localparam int CNT_W    = 7;   // node count register
	localparam int S_DATA_W = 16;  // from_node, to_node packed in the low 12 bits
	localparam int M_DATA_W = 8;   // safe_node packed to a byte

	localparam logic CMD_ADD_EDGE = 1'b0;
	localparam logic CMD_RUN      = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EDGE_RD,
		ST_EDGE_WR,
		ST_COUNT,
		ST_INIT,
		ST_SWEEP,
		ST_EMIT,
		ST_CLEAR
	} esn_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_edge;    // capture edge fields of an accepted add
		logic run_start;    // zero the degree counters
		logic edge_rd;      // read the destination row
		logic edge_wr;      // write the destination row back with the new bit
		logic cnt_issue;    // read row idx for degree counting
		logic init;         // seed safe and pending flags from zero degrees
		logic sweep_issue;  // read row idx, peel it if pending
		logic push_node;    // load a safe node result
		logic push_none;    // load the no-safe-node result
		logic clear;        // drop the graph and run flags
	} esn_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic at_end;     // idx has reached the node count
		logic pend_hit;   // node idx waits to be peeled
		logic safe_hit;   // node idx is safe
		logic safe_none;  // no node is safe
		logic safe_last;  // no safe node above idx
		logic out_free;   // result register can take a result this cycle
	} esn_status_t;

endpackage

// ----- rtl/core/eventual_safe_nodes_kahn.sv -----
// ----------------------------------------------------------------------------
// eventual_safe_nodes_kahn
// Finds the eventually safe nodes of a directed graph by a reverse Kahn peel.
// ----------------------------------------------------------------------------
// Edges are loaded with tuser 0 (from_node in tdata[5:0], to_node in
// tdata[11:6]); each load is the transfer, then a read and a write-back of
// the destination's predecessor row in the row RAM. A transfer with tuser 1
// runs the search and then empties the graph. With n = min(node_count,
// MAX_NODES) the run counts out-degrees (one RAM row per cycle), seeds the
// flags, then repeats peel sweeps until a sweep peels nothing (at most n + 1
// sweeps), then emits the safe nodes in ascending order and clears; the emit
// scan stalls while the result register is held by the sink. The last safe
// node carries tlast; a graph with no safe node gives one result with tuser
// set. node_count must be written on the cfg channel while the block is
// idle; the block itself does not enforce this.
module eventual_safe_nodes_kahn
	import esn_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,   // [5:0] from_node, [11:6] to_node
	input  logic [0:0]          s_tuser,   // [0] command
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,   // [5:0] safe_node
	output logic [0:0]          m_tuser,   // [0] none_found
	output logic                m_tlast,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CNT_W-1:0]    cfg_data
);

	esn_cmd_t                       cmd;
	esn_status_t                    sts;
	logic [$clog2(MAX_NODES+1)-1:0] idx;
	logic [NODE_W-1:0]              out_node;
	logic                           out_none;

	assign cfg_ready = 1'b1;
	assign m_tdata   = M_DATA_W'(out_node);
	assign m_tuser   = out_none;

	esn_ctrl #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_command(s_tuser[0]),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx)
	);

	esn_dp #(
		.MAX_NODES(MAX_NODES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.idx      (idx),
		.sts      (sts),
		.from_node(s_tdata[NODE_W-1:0]),
		.to_node  (s_tdata[2*NODE_W-1:NODE_W]),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_node (out_node),
		.out_none (out_none),
		.out_last (m_tlast)
	);

endmodule

// ----- rtl/core/esn_ram.sv -----
// ----------------------------------------------------------------------------
// esn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module esn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/esn_ctrl.sv -----
// ----------------------------------------------------------------------------
// esn_ctrl
// Sequencer for edge loads and the count, peel, emit and clear phases.
// ----------------------------------------------------------------------------
module esn_ctrl
	import esn_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_command,
	output logic                           in_ready,
	input  esn_status_t                    sts,
	output esn_cmd_t                       cmd,
	output logic [$clog2(MAX_NODES+1)-1:0] idx
);

	localparam int IW = $clog2(MAX_NODES + 1);

	esn_state_t    state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic          any_q, any_d;

	assign idx = idx_q;

	// State and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			any_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			any_q   <= any_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		any_d    = any_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				idx_d    = '0;
				if (in_valid) begin
					if (in_command == CMD_RUN) begin
						cmd.run_start = 1'b1;
						state_d       = ST_COUNT;
					end else begin
						cmd.load_edge = 1'b1;
						state_d       = ST_EDGE_RD;
					end
				end
			end
			ST_EDGE_RD: begin
				cmd.edge_rd = 1'b1;
				state_d     = ST_EDGE_WR;
			end
			ST_EDGE_WR: begin
				cmd.edge_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			// One row per cycle; the last row is summed while idx sits at the end
			ST_COUNT: begin
				if (sts.at_end) begin
					state_d = ST_INIT;
				end else begin
					cmd.cnt_issue = 1'b1;
					idx_d         = idx_q + 1'b1;
				end
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				idx_d    = '0;
				any_d    = 1'b0;
				state_d  = ST_SWEEP;
			end
			// Repeat sweeps until one of them peels nothing
			ST_SWEEP: begin
				if (sts.at_end) begin
					idx_d = '0;
					any_d = 1'b0;
					if (!any_q) begin
						state_d = ST_EMIT;
					end
				end else begin
					cmd.sweep_issue = 1'b1;
					any_d           = any_q | sts.pend_hit;
					idx_d           = idx_q + 1'b1;
				end
			end
			ST_EMIT: begin
				priority if (sts.safe_none) begin
					if (sts.out_free) begin
						cmd.push_none = 1'b1;
						state_d       = ST_CLEAR;
					end
				end else if (sts.safe_hit) begin
					if (sts.out_free) begin
						cmd.push_node = 1'b1;
						idx_d         = idx_q + 1'b1;
						if (sts.safe_last) begin
							state_d = ST_CLEAR;
						end
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/esn_dp.sv -----
// ----------------------------------------------------------------------------
// esn_dp
// Predecessor row store, per-node degree lanes, peel flags and result register.
// ----------------------------------------------------------------------------
module esn_dp
	import esn_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  esn_cmd_t                       cmd,
	input  logic [$clog2(MAX_NODES+1)-1:0] idx,
	output esn_status_t                    sts,
	input  logic [NODE_W-1:0]              from_node,
	input  logic [NODE_W-1:0]              to_node,
	input  logic                           cfg_valid,
	input  logic [CNT_W-1:0]               cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [NODE_W-1:0]              out_node,
	output logic                           out_none,
	output logic                           out_last
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int IW = $clog2(MAX_NODES + 1);
	localparam int DW = $clog2(MAX_NODES + 1);

	logic [CNT_W-1:0]     node_count_q;
	logic [CNT_W-1:0]     n_eff;
	logic [MAX_NODES-1:0] mask;

	logic [NODE_W-1:0]    from_q, to_q;
	logic                 edge_ok_q;

	logic [MAX_NODES-1:0] row_valid_q;
	logic                 rv_s1;
	logic                 cnt_s1, proc_s1;
	logic [MAX_NODES-1:0] ram_rdata, ram_wdata, row_raw, row_m;
	logic [AW-1:0]        ram_raddr, idx_a;
	logic                 ram_we;

	logic [DW-1:0]        deg_q [MAX_NODES];
	logic [MAX_NODES-1:0] safe_q, pend_q, above;

	assign idx_a = idx[AW-1:0];

	// Node count register; n_eff saturates it to the store size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(64);
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	assign n_eff = (node_count_q > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_q;
	assign sts.at_end = (CNT_W'(idx) >= n_eff);

	// Edge fields of an accepted add
	always_ff @(posedge clk) begin
		if (cmd.load_edge) begin
			from_q    <= from_node;
			to_q      <= to_node;
			edge_ok_q <= (CNT_W'(from_node) < CNT_W'(MAX_NODES)) &&
				(CNT_W'(to_node) < CNT_W'(MAX_NODES));
		end
	end

	// Row store: row t holds the predecessors of node t
	assign ram_raddr = cmd.edge_rd ? to_q[AW-1:0] : idx_a;
	assign ram_we    = cmd.edge_wr && edge_ok_q;
	assign row_raw   = rv_s1 ? ram_rdata : '0;
	assign row_m     = row_raw & mask;
	assign ram_wdata = row_raw | (MAX_NODES'(1) << from_q[AW-1:0]);

	esn_ram #(
		.WIDTH(MAX_NODES),
		.DEPTH(MAX_NODES)
	) u_rows (
		.clk  (clk),
		.we   (ram_we),
		.waddr(to_q[AW-1:0]),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Row valid bits and read-side pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rv_s1       <= 1'b0;
			cnt_s1      <= 1'b0;
			proc_s1     <= 1'b0;
		end else begin
			rv_s1   <= row_valid_q[ram_raddr];
			cnt_s1  <= cmd.cnt_issue;
			proc_s1 <= cmd.sweep_issue && pend_q[idx_a];
			if (cmd.clear) begin
				row_valid_q <= '0;
			end else if (ram_we) begin
				row_valid_q[to_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	// Per-node lanes: degree counter, safe and pending flags
	for (genvar i = 0; i < MAX_NODES; i++) begin : g_lane
		logic hit, dec_zero;

		assign mask[i]  = (CNT_W'(i) < n_eff);
		assign above[i] = safe_q[i] && (IW'(i) > idx);
		assign hit      = row_m[i];
		assign dec_zero = proc_s1 && hit && (deg_q[i] == DW'(1)) && !safe_q[i];

		always_ff @(posedge clk) begin
			if (cmd.run_start) begin
				deg_q[i] <= '0;
			end else if (cnt_s1 && hit) begin
				deg_q[i] <= deg_q[i] + 1'b1;
			end else if (proc_s1 && hit && (deg_q[i] != '0)) begin
				deg_q[i] <= deg_q[i] - 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				safe_q[i] <= 1'b0;
				pend_q[i] <= 1'b0;
			end else if (cmd.clear) begin
				safe_q[i] <= 1'b0;
				pend_q[i] <= 1'b0;
			end else if (cmd.init) begin
				safe_q[i] <= mask[i] && (deg_q[i] == '0);
				pend_q[i] <= mask[i] && (deg_q[i] == '0);
			end else if (dec_zero) begin
				safe_q[i] <= 1'b1;
				pend_q[i] <= 1'b1;
			end else if (cmd.sweep_issue && (idx_a == AW'(i))) begin
				pend_q[i] <= 1'b0;
			end
		end
	end

	assign sts.pend_hit  = pend_q[idx_a];
	assign sts.safe_hit  = safe_q[idx_a];
	assign sts.safe_none = ~|safe_q;
	assign sts.safe_last = ~|above;
	assign sts.out_free  = !out_valid || out_ready;

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.push_node || cmd.push_none) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_node) begin
			out_node <= NODE_W'(idx);
			out_none <= 1'b0;
			out_last <= sts.safe_last;
		end else if (cmd.push_none) begin
			out_node <= '0;
			out_none <= 1'b1;
			out_last <= 1'b1;
		end
	end

endmodule
